### rtl/rdh_pkg.sv
package rdh_pkg;

   localparam int SpeciesDefault = 4;
   localparam int NumBinsDefault = 256;

   localparam int CoordW = 20;
   localparam int BoxW = 19;
   localparam int BinsUseW = 9;
   localparam int CountW = 32;
   localparam int OutBinW = 8;
   localparam int SpecW = 2;

   // Wrapped differences stay within 21 bits signed; squares of those sum below 2^43.
   localparam int DiffW = 22;
   localparam int SumW = 44;
   localparam int RootW = 22;

   localparam logic [BoxW-1:0] BoxReset = 19'd30720;
   localparam logic [BoxW-1:0] WidthReset = 19'd102;
   localparam logic [BinsUseW-1:0] BinsReset = 9'd256;

   typedef enum logic [1:0] {
      CSR_BOX_LENGTH = 2'd0,
      CSR_BIN_WIDTH = 2'd1,
      CSR_BINS_IN_USE = 2'd2
   } csr_index_type;

   localparam logic OP_ACCUMULATE = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Classified beat handed from the front end to the histogram engine.
   typedef struct packed {
      logic is_read;
      logic [SpecW-1:0] species_a;
      logic [SpecW-1:0] species_b;
      logic same_particle;
      logic [OutBinW-1:0] read_bin;
      logic signed [CoordW-1:0] x_a;
      logic signed [CoordW-1:0] y_a;
      logic signed [CoordW-1:0] z_a;
      logic signed [CoordW-1:0] x_b;
      logic signed [CoordW-1:0] y_b;
      logic signed [CoordW-1:0] z_b;
   } beat_type;

endpackage

### rtl/rdh_front.sv
module rdh_front
   import rdh_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  beat_type in_beat,
   output logic in_ready,
   output logic out_valid,
   output beat_type out_beat,
   input  logic out_ready
);

   // Two-entry queue that decouples command acceptance from the engine.
   localparam int Depth = 2;

   beat_type slot_ff [Depth];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic push, pop;

   assign in_ready = (fill_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign out_valid = (fill_ff != 2'd0);
   assign pop = out_valid && out_ready;
   assign out_beat = slot_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_beat;
      end
   end

   assert property (@(posedge clock) disable iff (reset) fill_ff <= 2'd2)
      else $error("queue fill out of range");
   assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd2) |-> !in_ready)
      else $error("queue accepts while full");
   assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd0) |-> !out_valid)
      else $error("queue offers beat while empty");

endmodule

### rtl/rdh_engine.sv
module rdh_engine
   import rdh_pkg::*;
#(
   parameter int SPECIES = SpeciesDefault,
   parameter int NUM_BINS = NumBinsDefault
)(
   input  logic clock,
   input  logic reset,
   input  logic [BoxW-1:0] box_length,
   input  logic [BoxW-1:0] bin_width,
   input  logic [BinsUseW-1:0] bins_in_use,
   input  logic in_valid,
   input  beat_type in_beat,
   output logic in_ready,
   output logic rsp_valid,
   output logic [CountW-1:0] rsp_bin_count,
   output logic rsp_counted,
   output logic [OutBinW-1:0] rsp_computed_bin
);

   localparam int BinIdxW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int SpIdxW = (SPECIES > 1) ? $clog2(SPECIES) : 1;
   localparam int Depth = SPECIES * SPECIES * NUM_BINS;
   localparam int AddrW = $clog2(Depth);
   localparam int QuoW = RootW;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_WRAP, ST_SQUARE, ST_SUM, ST_ROOT, ST_DIV,
      ST_CHECK, ST_READ, ST_WRITE, ST_RESPOND
   } state_type;

   state_type state_ff;
   beat_type beat_ff;
   logic [AddrW-1:0] clr_addr_ff;
   logic signed [DiffW-1:0] dx_ff, dy_ff, dz_ff;
   logic [SumW-1:0] sq_x_ff, sq_y_ff, sq_z_ff;
   logic [SumW-1:0] rem_ff;
   logic [RootW-1:0] root_ff;
   logic [QuoW-1:0] quo_ff;
   logic [RootW-1:0] div_rem_ff;
   logic [4:0] step_ff;
   logic ok_ff;
   logic [AddrW-1:0] addr_ff;
   logic [CountW-1:0] rd_data_ff;
   logic [CountW-1:0] count_ff;
   logic [OutBinW-1:0] out_bin_ff;
   logic rsp_valid_ff;

   logic [CountW-1:0] hist_mem [Depth];

   // Single wrap of one coordinate difference against the box length.
   function automatic logic signed [DiffW-1:0] wrap_diff(
      input logic signed [CoordW-1:0] a,
      input logic signed [CoordW-1:0] b,
      input logic [BoxW-1:0] len
   );
      logic signed [DiffW-1:0] d;
      logic signed [DiffW:0] twice;
      logic signed [DiffW:0] slen;
      begin
         d = DiffW'(a) - DiffW'(b);
         twice = {d, 1'b0};
         slen = (DiffW+1)'({1'b0, len});
         if (twice > slen) begin
            wrap_diff = d - DiffW'(slen);
         end else if (twice < -slen) begin
            wrap_diff = d + DiffW'(slen);
         end else begin
            wrap_diff = d;
         end
      end
   endfunction

   function automatic logic [SumW-1:0] square(input logic signed [DiffW-1:0] d);
      logic [DiffW-1:0] m;
      begin
         m = d[DiffW-1] ? DiffW'(-d) : d;
         square = SumW'(m) * SumW'(m);
      end
   endfunction

   // Combinational helpers for one root step and one divide step.
   logic [SumW-1:0] trial;
   logic [SumW-1:0] bitval;
   logic [RootW:0] div_trial;
   logic [BoxW-1:0] width_eff;
   logic bin_ok;
   logic [SpIdxW-1:0] sa_idx, sb_idx;
   logic [BinIdxW-1:0] bin_idx;
   logic sp_ok;

   assign bitval = SumW'(1) << {step_ff, 1'b0};
   assign trial = ({root_ff, {(SumW-RootW){1'b0}}} >> (RootW - 1 - int'(step_ff)))
                  | bitval;
   assign width_eff = (bin_width == '0) ? BoxW'(1) : bin_width;
   assign div_trial = {div_rem_ff, 1'b0} | (RootW+1)'(root_ff[step_ff]);
   assign sa_idx = SpIdxW'(beat_ff.species_a);
   assign sb_idx = SpIdxW'(beat_ff.species_b);
   assign bin_idx = beat_ff.is_read ? BinIdxW'(beat_ff.read_bin) : BinIdxW'(quo_ff);
   assign sp_ok = (32'(beat_ff.species_a) < SPECIES) && (32'(beat_ff.species_b) < SPECIES);
   assign bin_ok = (quo_ff < QuoW'(bins_in_use)) && (32'(quo_ff) < NUM_BINS);

   assign in_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_bin_count = count_ff;
   assign rsp_counted = ok_ff;
   assign rsp_computed_bin = out_bin_ff;

   // Sequencer: clear sweep, wrap, square, sum, bit-serial root and divide, then
   // read-modify-write of one histogram entry; a read beat skips to the entry read.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         ok_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + AddrW'(1);
               if (32'(clr_addr_ff) == Depth - 1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (in_valid) begin
                  beat_ff <= in_beat;
                  state_ff <= in_beat.is_read ? ST_CHECK : ST_WRAP;
               end
            end
            ST_WRAP: begin
               dx_ff <= wrap_diff(beat_ff.x_a, beat_ff.x_b, box_length);
               dy_ff <= wrap_diff(beat_ff.y_a, beat_ff.y_b, box_length);
               dz_ff <= wrap_diff(beat_ff.z_a, beat_ff.z_b, box_length);
               state_ff <= ST_SQUARE;
            end
            ST_SQUARE: begin
               sq_x_ff <= square(dx_ff);
               sq_y_ff <= square(dy_ff);
               sq_z_ff <= square(dz_ff);
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               rem_ff <= sq_x_ff + sq_y_ff + sq_z_ff;
               root_ff <= '0;
               step_ff <= 5'(RootW - 1);
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               // One result bit per cycle, most significant first.
               if (rem_ff >= trial) begin
                  rem_ff <= rem_ff - trial;
                  root_ff <= root_ff | (RootW'(1) << step_ff);
               end
               if (step_ff == '0) begin
                  step_ff <= 5'(RootW - 1);
                  div_rem_ff <= '0;
                  quo_ff <= '0;
                  state_ff <= ST_DIV;
               end else begin
                  step_ff <= step_ff - 5'd1;
               end
            end
            ST_DIV: begin
               // Restoring divide of the root by the bin width, one bit a cycle.
               if (div_trial >= (RootW+1)'(width_eff)) begin
                  div_rem_ff <= RootW'(div_trial - (RootW+1)'(width_eff));
                  quo_ff <= {quo_ff[QuoW-2:0], 1'b1};
               end else begin
                  div_rem_ff <= RootW'(div_trial);
                  quo_ff <= {quo_ff[QuoW-2:0], 1'b0};
               end
               if (step_ff == '0) begin
                  state_ff <= ST_CHECK;
               end else begin
                  step_ff <= step_ff - 5'd1;
               end
            end
            ST_CHECK: begin
               if (beat_ff.is_read) begin
                  out_bin_ff <= beat_ff.read_bin;
                  addr_ff <= AddrW'((32'(sa_idx) * SPECIES + 32'(sb_idx)) * NUM_BINS
                                    + 32'(bin_idx));
                  ok_ff <= 1'b0;
                  step_ff <= {4'd0, sp_ok && (32'(beat_ff.read_bin) < NUM_BINS)};
               end else begin
                  out_bin_ff <= (quo_ff > QuoW'(255)) ? 8'd255 : quo_ff[7:0];
                  ok_ff <= !beat_ff.same_particle && (beat_ff.species_a <= beat_ff.species_b)
                           && sp_ok && bin_ok;
                  addr_ff <= AddrW'((32'(sa_idx) * SPECIES + 32'(sb_idx)) * NUM_BINS
                                    + 32'(bin_idx));
               end
               state_ff <= ST_READ;
            end
            ST_READ: begin
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               if (beat_ff.is_read) begin
                  count_ff <= step_ff[0] ? rd_data_ff : '0;
               end else if (ok_ff) begin
                  count_ff <= (&rd_data_ff) ? rd_data_ff : rd_data_ff + CountW'(1);
               end else begin
                  count_ff <= '0;
               end
               state_ff <= ST_RESPOND;
            end
            ST_RESPOND: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Histogram store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= hist_mem[addr_ff];
      if (state_ff == ST_CLEAR) begin
         hist_mem[clr_addr_ff] <= '0;
      end else if (state_ff == ST_WRITE && !beat_ff.is_read && ok_ff && !(&rd_data_ff)) begin
         hist_mem[addr_ff] <= rd_data_ff + CountW'(1);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_RESPOND)
      else $error("response outside respond step");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_counted) |-> rsp_bin_count != '0)
      else $error("counted beat reports zero count");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !in_ready)
      else $error("accepting during clear sweep");

endmodule

### rtl/radial_distribution_histogram.sv
// Channel  | Direction | Handshake                      | Payload
// request  | in        | start high, busy low           | req_opcode .. req_read_bin
// response | out       | rsp_strobe, one cycle          | rsp_bin_count, counted, bin
// csr      | in        | csr_write_enable               | csr_index, csr_write_data
//
// An accumulate passes through the engine steps wrap, square, sum, a 22-step
// bit-serial square root, a 22-step divide by the bin width, then a read and a write
// of the histogram memory. A read skips the arithmetic and only reads the memory.
// After reset the histogram memory is cleared, one entry a cycle, over all
// SPECIES*SPECIES*NUM_BINS entries (4096 by default); requests wait during it.
// A two-entry queue lets two requests be taken while the engine works.
// Results cannot be stalled; each is shown for one cycle.
module radial_distribution_histogram
   import rdh_pkg::*;
#(
   parameter int SPECIES = SpeciesDefault,
   parameter int NUM_BINS = NumBinsDefault
)(
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic req_opcode,
   input  logic signed [CoordW-1:0] req_x_a,
   input  logic signed [CoordW-1:0] req_y_a,
   input  logic signed [CoordW-1:0] req_z_a,
   input  logic signed [CoordW-1:0] req_x_b,
   input  logic signed [CoordW-1:0] req_y_b,
   input  logic signed [CoordW-1:0] req_z_b,
   input  logic [SpecW-1:0] req_species_a,
   input  logic [SpecW-1:0] req_species_b,
   input  logic req_same_particle,
   input  logic [OutBinW-1:0] req_read_bin,
   output logic rsp_strobe,
   output logic [CountW-1:0] rsp_bin_count,
   output logic rsp_counted,
   output logic [OutBinW-1:0] rsp_computed_bin,
   input  logic csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [BoxW-1:0] csr_write_data
);

   logic [BoxW-1:0] box_length_ff;
   logic [BoxW-1:0] bin_width_ff;
   logic [BinsUseW-1:0] bins_in_use_ff;
   beat_type req_beat, q_beat;
   logic q_valid, q_ready, in_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         box_length_ff <= BoxReset;
         bin_width_ff <= WidthReset;
         bins_in_use_ff <= BinsReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BOX_LENGTH: box_length_ff <= csr_write_data;
            CSR_BIN_WIDTH: bin_width_ff <= csr_write_data;
            CSR_BINS_IN_USE: bins_in_use_ff <= csr_write_data[BinsUseW-1:0];
            default: ;
         endcase
      end
   end

   // Pack the request beat.
   always_comb begin
      req_beat.is_read = (req_opcode == OP_READ);
      req_beat.species_a = req_species_a;
      req_beat.species_b = req_species_b;
      req_beat.same_particle = req_same_particle;
      req_beat.read_bin = req_read_bin;
      req_beat.x_a = req_x_a;
      req_beat.y_a = req_y_a;
      req_beat.z_a = req_z_a;
      req_beat.x_b = req_x_b;
      req_beat.y_b = req_y_b;
      req_beat.z_b = req_z_b;
   end

   assign busy = !in_ready;

   rdh_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(start), .in_beat(req_beat), .in_ready(in_ready),
      .out_valid(q_valid), .out_beat(q_beat), .out_ready(q_ready)
   );

   rdh_engine #(.SPECIES(SPECIES), .NUM_BINS(NUM_BINS)) u_engine (
      .clock(clock), .reset(reset),
      .box_length(box_length_ff), .bin_width(bin_width_ff),
      .bins_in_use(bins_in_use_ff),
      .in_valid(q_valid), .in_beat(q_beat), .in_ready(q_ready),
      .rsp_valid(rsp_strobe), .rsp_bin_count(rsp_bin_count),
      .rsp_counted(rsp_counted), .rsp_computed_bin(rsp_computed_bin)
   );

endmodule

### tb/radial_distribution_histogram_checker.sv
`timescale 1ns / 1ps

module radial_distribution_histogram_checker
   import rdh_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic busy,
   input  logic req_opcode,
   input  logic signed [CoordW-1:0] req_x_a,
   input  logic signed [CoordW-1:0] req_y_a,
   input  logic signed [CoordW-1:0] req_z_a,
   input  logic signed [CoordW-1:0] req_x_b,
   input  logic signed [CoordW-1:0] req_y_b,
   input  logic signed [CoordW-1:0] req_z_b,
   input  logic [SpecW-1:0] req_species_a,
   input  logic [SpecW-1:0] req_species_b,
   input  logic req_same_particle,
   input  logic [OutBinW-1:0] req_read_bin,
   input  logic rsp_strobe,
   input  logic [CountW-1:0] rsp_bin_count,
   input  logic rsp_counted,
   input  logic [OutBinW-1:0] rsp_computed_bin,
   input  logic csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [BoxW-1:0] csr_write_data,
   output int failures,
   output int pending
);

   typedef struct {
      logic [CountW-1:0] bin_count;
      logic counted;
      logic [OutBinW-1:0] computed_bin;
   } bin_report_type;

   bin_report_type reports_due[$];
   logic [CountW-1:0] counts [0:4095];
   longint box_len, bin_w, bins_used;

   assign pending = reports_due.size();

   // Wrap one coordinate difference once by the box length; ties stay put.
   function automatic longint wrapped(longint d);
      if (2 * d > box_len) return d - box_len;
      if (2 * d < -box_len) return d + box_len;
      return d;
   endfunction

   function automatic longint floor_root(longint v);
      longint r;
      r = longint'($sqrt(real'(v)));
      while (r * r > v) r--;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
   endfunction

   // Predict the report of one accepted beat; an accumulate also updates the histogram copy.
   function automatic bin_report_type predict_bin_report();
      bin_report_type rep;
      longint dx, dy, dz, bin;
      int idx;
      rep.counted = 1'b0;
      rep.bin_count = '0;
      if (req_opcode == OP_READ) begin
         rep.computed_bin = req_read_bin;
         rep.bin_count = counts[{req_species_a, req_species_b, req_read_bin}];
         return rep;
      end
      dx = wrapped(longint'(req_x_a) - longint'(req_x_b));
      dy = wrapped(longint'(req_y_a) - longint'(req_y_b));
      dz = wrapped(longint'(req_z_a) - longint'(req_z_b));
      bin = floor_root(dx * dx + dy * dy + dz * dz) / (bin_w == 0 ? 1 : bin_w);
      rep.computed_bin = bin > 255 ? 8'd255 : OutBinW'(bin);
      if (!req_same_particle && req_species_a <= req_species_b && bin < bins_used
          && bin < 256) begin
         idx = {req_species_a, req_species_b, 8'(bin)};
         if (counts[idx] != '1) counts[idx] = counts[idx] + 1;
         rep.counted = 1'b1;
         rep.bin_count = counts[idx];
      end
      return rep;
   endfunction

   always @(posedge clock) begin
      bin_report_type want;
      if (reset) begin
         for (int i = 0; i < 4096; i++) counts[i] = '0;
         box_len = BoxReset;
         bin_w = WidthReset;
         bins_used = BinsReset;
         reports_due.delete();
         failures = 0;
      end else begin
         // Compare a result beat with the oldest expectation.
         if (rsp_strobe) begin
            if (reports_due.size() == 0) begin
               $error("unexpected result beat");
               failures++;
            end else begin
               want = reports_due.pop_front();
               if (rsp_bin_count !== want.bin_count) begin
                  $error("bin_count expected %0d actual %0d", want.bin_count,
                         rsp_bin_count);
                  failures++;
               end
               if (rsp_counted !== want.counted) begin
                  $error("counted expected %0d actual %0d", want.counted, rsp_counted);
                  failures++;
               end
               if (rsp_computed_bin !== want.computed_bin) begin
                  $error("computed_bin expected %0d actual %0d", want.computed_bin,
                         rsp_computed_bin);
                  failures++;
               end
            end
         end
         if (start && !busy) reports_due.push_back(predict_bin_report());
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BOX_LENGTH: box_len = csr_write_data;
               CSR_BIN_WIDTH: bin_w = csr_write_data;
               CSR_BINS_IN_USE: bins_used = csr_write_data[BinsUseW-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

### tb/radial_distribution_histogram_tb.sv
`timescale 1ns / 1ps

module radial_distribution_histogram_tb;
   import rdh_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_opcode = OP_ACCUMULATE;
   logic signed [CoordW-1:0] req_x_a = '0, req_y_a = '0, req_z_a = '0;
   logic signed [CoordW-1:0] req_x_b = '0, req_y_b = '0, req_z_b = '0;
   logic [SpecW-1:0] req_species_a = '0, req_species_b = '0;
   logic req_same_particle = 1'b0;
   logic [OutBinW-1:0] req_read_bin = '0;
   logic rsp_strobe;
   logic [CountW-1:0] rsp_bin_count;
   logic rsp_counted;
   logic [OutBinW-1:0] rsp_computed_bin;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = '0;
   logic [BoxW-1:0] csr_write_data = '0;
   int failures, pending;
   bit calm;

   always #2 clock = ~clock;

   radial_distribution_histogram uut (.*);
   radial_distribution_histogram_checker histogram_checker (.*);

   // Hold the beat until the block takes it. Start stays high so that a following
   // beat can go back to back; an idle gap or a register write drops it.
   task automatic send_pair(logic op, int xa, int ya, int za, int xb, int yb, int zb,
                            int sa, int sb, bit same, int rbin);
      if (!calm && $urandom_range(3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_x_a <= CoordW'(xa); req_y_a <= CoordW'(ya); req_z_a <= CoordW'(za);
      req_x_b <= CoordW'(xb); req_y_b <= CoordW'(yb); req_z_b <= CoordW'(zb);
      req_species_a <= SpecW'(sa); req_species_b <= SpecW'(sb);
      req_same_particle <= same; req_read_bin <= OutBinW'(rbin);
      do @(posedge clock); while (busy);
   endtask

   task automatic read_bin(int sa, int sb, int rbin);
      send_pair(OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                sa, sb, 1'($urandom), rbin);
   endtask

   task automatic write_reg(csr_index_type idx, int value);
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= BoxW'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Random pair: mostly close particles that land in counted bins.
   task automatic random_pair(int spread);
      int xa, ya, za;
      xa = $urandom; ya = $urandom; za = $urandom;
      if ($urandom_range(4) == 0)
         send_pair(OP_ACCUMULATE, xa, ya, za, $urandom, $urandom, $urandom,
                   $urandom, $urandom, 1'($urandom), $urandom);
      else if ($urandom_range(5) == 0)
         read_bin($urandom, $urandom, $urandom);
      else
         send_pair(OP_ACCUMULATE, xa, ya, za,
                   xa + int'($urandom_range(2 * spread)) - spread,
                   ya + int'($urandom_range(2 * spread)) - spread,
                   za + int'($urandom_range(2 * spread)) - spread,
                   $urandom_range(1), $urandom_range(1, 3), $urandom_range(9) == 0,
                   $urandom);
   endtask

   initial begin
      calm = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // Directed: extremes of coordinates, ties, species order, self pairs, reads.
      send_pair(OP_ACCUMULATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_pair(OP_ACCUMULATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_pair(OP_ACCUMULATE, 524287, -524288, 524287, -524288, 524287, -524288,
                3, 3, 0, 255);
      send_pair(OP_ACCUMULATE, -524288, 524287, 0, 524287, -524288, 0, 0, 3, 0, 0);
      send_pair(OP_ACCUMULATE, 15360, 0, 0, 0, 0, 0, 1, 2, 0, 0);
      send_pair(OP_ACCUMULATE, 15361, -15361, 0, 0, 0, 0, 1, 2, 0, 0);
      send_pair(OP_ACCUMULATE, 0, 500, 0, 0, 0, 0, 2, 1, 0, 0);
      send_pair(OP_ACCUMULATE, 0, 500, 0, 0, 0, 0, 2, 2, 1, 0);
      send_pair(OP_ACCUMULATE, 0, 0, 26112, 0, 0, 0, 0, 1, 0, 0);
      read_bin(0, 0, 0);
      read_bin(1, 2, 150);
      read_bin(3, 3, 255);
      read_bin(2, 1, 4);
      write_reg(CSR_BOX_LENGTH, 0);
      write_reg(CSR_BIN_WIDTH, 0);
      write_reg(CSR_BINS_IN_USE, 0);
      send_pair(OP_ACCUMULATE, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      write_reg(CSR_BINS_IN_USE, 256);
      send_pair(OP_ACCUMULATE, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_pair(OP_ACCUMULATE, 200, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      read_bin(0, 0, 100);
      write_reg(CSR_BOX_LENGTH, 524287);
      write_reg(CSR_BIN_WIDTH, 524287);
      send_pair(OP_ACCUMULATE, 524287, 524287, 524287, -524288, -524288, -524288,
                0, 1, 0, 0);
      write_reg(CSR_BIN_WIDTH, 1);
      write_reg(CSR_BOX_LENGTH, 1);
      send_pair(OP_ACCUMULATE, 0, 1, 0, 0, 0, 0, 0, 1, 0, 0);
      // Random phases over several register settings.
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin write_reg(CSR_BOX_LENGTH, 30720); write_reg(CSR_BIN_WIDTH, 102);
               write_reg(CSR_BINS_IN_USE, 256); end
            1: begin write_reg(CSR_BOX_LENGTH, $urandom_range(1, 524287));
               write_reg(CSR_BIN_WIDTH, $urandom_range(1, 4000)); end
            2: begin write_reg(CSR_BINS_IN_USE, 1); write_reg(CSR_BIN_WIDTH, 1000); end
            3: begin write_reg(CSR_BINS_IN_USE, $urandom_range(1, 255));
               write_reg(CSR_BIN_WIDTH, $urandom_range(1, 20)); end
            4: begin write_reg(CSR_BOX_LENGTH, 2048); write_reg(CSR_BIN_WIDTH, 8);
               write_reg(CSR_BINS_IN_USE, 256); end
            5: write_reg(CSR_BOX_LENGTH, $urandom);
            default: begin write_reg(CSR_BOX_LENGTH, 30720);
               write_reg(CSR_BIN_WIDTH, 50); calm = 1; end
         endcase
         for (int i = 0; i < 100; i++) random_pair(phase == 4 ? 1500 : 4000);
         for (int i = 0; i < 4; i++) read_bin($urandom, $urandom, $urandom);
      end
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (failures == 0) $display("radial_distribution_histogram verification clean");
      else $display("radial_distribution_histogram verification failed");
      $finish;
   end

   initial begin
      #3000000;
      $display("radial_distribution_histogram verification failed");
      $finish;
   end

endmodule
